### rtl/core/mailbox_syntax_checker_top_macros.svh
// Assertion macros for the mailbox syntax checker's checker module.
// Needs nothing but a clock and an active-low synchronous reset in scope.
`ifndef MAILBOX_SYNTAX_CHECKER_TOP_MACROS_SVH
`define MAILBOX_SYNTAX_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define MSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked across reset.
`define MSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/msc_pkg.sv
// Character constants and byte classes for the mailbox syntax checker.
// No dependencies.
`default_nettype none

package msc_pkg;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
               (c >= CH_UC_LO && c <= CH_UC_HI) ||
               (c >= CH_LC_LO && c <= CH_LC_HI);
    endfunction

endpackage

`default_nettype wire

### rtl/core/mailbox_syntax_checker_top.sv
// Mailbox syntax checker: one byte per cycle in, one verdict per string out.
// The verdict for a string is written to the result register as its last byte
// leaves the input register. Throughput: one byte per cycle unless a last byte
// waits behind a stalled verdict, set by the combinational parse update.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the leading-whitespace phase.
`default_nettype none

module mailbox_syntax_checker_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_last_char,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_mailbox_valid
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_DOT,
        PH_QOPEN,
        PH_QDONE,
        PH_DOMAIN
    } t_phase;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_last;

    // parser state
    t_phase r_phase, n_phase;
    logic   r_label, n_label;
    logic   r_space, n_space;
    logic   r_nonempty, n_nonempty;
    logic   r_failed, n_failed;

    // result register
    logic r_out_valid;
    logic r_mailbox_valid;

    logic w_out_free;
    logic w_s1_drain;
    logic w_in_accept;
    logic w_ws;
    logic w_alnum;
    logic w_ok;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_drain  = r_s1_valid && (!r_s1_last || w_out_free);
    assign o_in_stall  = r_s1_valid && !w_s1_drain;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_ws    = msc_pkg::is_ws(r_s1_char);
    assign w_alnum = msc_pkg::is_alnum(r_s1_char);

    always_comb begin
        n_phase    = r_phase;
        n_label    = r_label;
        n_space    = r_space;
        n_nonempty = r_nonempty;
        n_failed   = r_failed;
        if (!r_failed) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (!w_ws) begin
                        if (r_s1_char == msc_pkg::CH_AT) begin
                            n_failed = 1'b1;
                        end else if (r_s1_char == msc_pkg::CH_QUOTE) begin
                            n_phase = PH_QOPEN;
                        end else begin
                            n_phase = PH_DOT;
                            n_label = 1'b1;
                            if (w_alnum) begin
                                n_label = 1'b0;
                            end else if (r_s1_char == msc_pkg::CH_DOT) begin
                                // leading dot of the local part
                                n_failed = 1'b1;
                            end
                        end
                    end
                end
                PH_DOT: begin
                    if (r_s1_char == msc_pkg::CH_AT) begin
                        n_phase = PH_DOMAIN;
                        n_label = 1'b1;
                    end else if (w_alnum) begin
                        n_label = 1'b0;
                    end else if (r_s1_char == msc_pkg::CH_DOT) begin
                        if (r_label) begin
                            n_failed = 1'b1;
                        end
                        n_label = 1'b1;
                    end
                end
                PH_QOPEN: begin
                    if (r_s1_char == msc_pkg::CH_AT) begin
                        n_phase = PH_DOMAIN;
                        n_label = 1'b1;
                    end else if (r_s1_char == msc_pkg::CH_QUOTE) begin
                        n_phase = PH_QDONE;
                    end
                end
                PH_QDONE: begin
                    if (r_s1_char == msc_pkg::CH_AT) begin
                        n_phase = PH_DOMAIN;
                        n_label = 1'b1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_DOMAIN: begin
                    if (w_ws) begin
                        n_space = 1'b1;
                    end else if (r_space) begin
                        // text after whitespace inside the domain
                        n_failed = 1'b1;
                    end else begin
                        n_nonempty = 1'b1;
                        if (w_alnum) begin
                            n_label = 1'b0;
                        end else if (r_s1_char == msc_pkg::CH_DASH ||
                                     r_s1_char == msc_pkg::CH_DOT) begin
                            if (r_label) begin
                                n_failed = 1'b1;
                            end
                            if (r_s1_char == msc_pkg::CH_DOT) begin
                                n_label = 1'b1;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    assign w_ok = !n_failed && (n_phase == PH_DOMAIN) && n_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEAD;
            r_label     <= 1'b1;
            r_space     <= 1'b0;
            r_nonempty  <= 1'b0;
            r_failed    <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_drain) begin
                r_s1_valid <= 1'b0;
            end

            if (w_out_free) begin
                r_out_valid <= w_s1_drain && r_s1_last;
            end

            if (w_s1_drain) begin
                if (r_s1_last) begin
                    // verdict given: restart for the next string
                    r_phase    <= PH_LEAD;
                    r_label    <= 1'b1;
                    r_space    <= 1'b0;
                    r_nonempty <= 1'b0;
                    r_failed   <= 1'b0;
                end else begin
                    r_phase    <= n_phase;
                    r_label    <= n_label;
                    r_space    <= n_space;
                    r_nonempty <= n_nonempty;
                    r_failed   <= n_failed;
                end
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_char <= i_char_in;
            r_s1_last <= i_last_char;
        end
        if (w_s1_drain && r_s1_last) begin
            r_mailbox_valid <= w_ok;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mailbox_valid = r_mailbox_valid;

endmodule

`default_nettype wire

### rtl/core/msc_checker.sv
// Port-level assertions for the mailbox syntax checker, bound to the top level.
// Uses the macros in mailbox_syntax_checker_top_macros.svh.
`default_nettype none

`include "mailbox_syntax_checker_top_macros.svh"

module msc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_mailbox_valid
);

    // a stalled verdict holds its value
    `MSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_mailbox_valid))

    // the input side backs up only behind a stalled verdict
    `MSC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // reset empties the result register and clears the input stall
    `MSC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind mailbox_syntax_checker_top msc_checker u_msc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_mailbox_valid(o_mailbox_valid)
);

`default_nettype wire
